### rtl/core/overwriting_history_fifo_core_defines.svh
// Assertion helpers for the history FIFO.
`ifndef OVERWRITING_HISTORY_FIFO_CORE_DEFINES_SVH
`define OVERWRITING_HISTORY_FIFO_CORE_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define OHF_ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define OHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ohf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ohf_pkg;

  localparam int MODE_W      = 2;
  localparam int DATA_W      = 64;
  localparam int COUNT_W     = 5;
  localparam int MAX_RESULTS = 16;

  // operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPLAY = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [DATA_W-1:0]  entry_data;
    logic [COUNT_W-1:0] replay_count;
  } ohf_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]  out_data;
    logic               refused;
    logic               dropped_oldest;
    logic               last_of_run;
    logic [COUNT_W-1:0] fill_level;
  } ohf_out_t;

  // controller to datapath
  typedef struct packed {
    logic push;       // store the item, give a direct result
    logic pop;        // read oldest, advance
    logic rep_setup;  // load replay pointer with the first slot
    logic rep_read;   // read at replay pointer, advance it
    logic rd_last;    // this read ends the run
    logic refuse;     // give a refusal result
  } ohf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic               op_push;
    logic               op_pop_ok;
    logic               op_replay_ok;
    logic [COUNT_W-1:0] replay_n;
    logic               rd_pend;
  } ohf_status_t;

endpackage

`default_nettype wire

### rtl/core/ohf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ohf_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  ohf_pkg::ohf_status_t status_i,
  output ohf_pkg::ohf_cmd_t    cmd_o
);
  import ohf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLAY,
    ST_DRAIN
  } state_e;

  state_e             state_q, state_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic               accept;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // command decode and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    rem_d   = rem_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (status_i.op_push) begin
            cmd_o.push = 1'b1;
          end else if (status_i.op_pop_ok) begin
            cmd_o.pop     = 1'b1;
            cmd_o.rd_last = 1'b1;
            state_d       = ST_DRAIN;
          end else if (status_i.op_replay_ok) begin
            cmd_o.rep_setup = 1'b1;
            rem_d           = status_i.replay_n;
            state_d         = ST_REPLAY;
          end else begin
            cmd_o.refuse = 1'b1;
          end
        end
      end
      ST_REPLAY: begin
        cmd_o.rep_read = 1'b1;
        cmd_o.rd_last  = (rem_q == COUNT_W'(1));
        rem_d          = rem_q - COUNT_W'(1);
        if (rem_q == COUNT_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data goes to the result register this cycle
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ohf_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module ohf_dpath #(
  parameter int DEPTH      = 16,
  parameter int ENTRY_BITS = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ohf_pkg::ohf_in_t     in_i,
  input  ohf_pkg::ohf_cmd_t    cmd_i,
  output ohf_pkg::ohf_status_t status_o,
  output ohf_pkg::ohf_out_t    res_o,
  output logic                 res_valid_o
);
  import ohf_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

  // slot arithmetic: sums stay below twice the depth
  function automatic logic [AW-1:0] wrap(input logic [AW:0] sum);
    logic [AW:0] red;
    red = (sum >= (AW+1)'(DEPTH)) ? sum - (AW+1)'(DEPTH) : sum;
    return red[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  logic [ENTRY_BITS-1:0] mem [DEPTH];

  logic [AW-1:0]         oldest_q, oldest_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         rp_q;
  logic [ENTRY_BITS-1:0] rd_data_q;
  logic                  rd_valid_q, rd_last_q;
  ohf_out_t              res_q, res_d;
  logic                  res_valid_q;

  logic                  full, empty;
  logic [AW-1:0]         wr_addr, rd_addr, first_slot;
  logic [CW-1:0]         keep_n;
  logic                  direct;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // status for the controller
  assign status_o.op_push      = (in_i.mode == MODE_PUSH);
  assign status_o.op_pop_ok    = (in_i.mode == MODE_POP) && !empty;
  assign status_o.op_replay_ok = (in_i.mode == MODE_REPLAY)
                               && (in_i.replay_count != '0)
                               && (CMPW'(in_i.replay_count) <= CMPW'(count_q))
                               && (in_i.replay_count <= COUNT_W'(MAX_RESULTS));
  assign status_o.replay_n     = in_i.replay_count;
  assign status_o.rd_pend      = rd_valid_q;

  // addresses
  assign wr_addr    = wrap({1'b0, oldest_q} + (AW+1)'(count_q));
  assign keep_n     = count_q - CW'(in_i.replay_count);
  assign first_slot = wrap({1'b0, oldest_q} + (AW+1)'(keep_n));
  assign rd_addr    = cmd_i.pop ? oldest_q : rp_q;

  // pointer and fill updates
  always_comb begin
    oldest_d = oldest_q;
    count_d  = count_q;
    if (cmd_i.push) begin
      if (full) begin
        oldest_d = inc(oldest_q);
      end else begin
        count_d = count_q + CW'(1);
      end
    end else if (cmd_i.pop) begin
      oldest_d = inc(oldest_q);
      count_d  = count_q - CW'(1);
    end
  end

  // result register input
  assign direct = cmd_i.push || cmd_i.refuse;
  always_comb begin
    res_d = res_q;
    if (direct) begin
      res_d.out_data       = '0;
      res_d.refused        = cmd_i.refuse;
      res_d.dropped_oldest = cmd_i.push && full;
      res_d.last_of_run    = 1'b1;
      res_d.fill_level     = COUNT_W'(count_d);
    end else if (rd_valid_q) begin
      res_d.out_data       = DATA_W'(rd_data_q);
      res_d.refused        = 1'b0;
      res_d.dropped_oldest = 1'b0;
      res_d.last_of_run    = rd_last_q;
      res_d.fill_level     = COUNT_W'(count_q);
    end
  end

  // entry store, read data and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= in_i.entry_data[ENTRY_BITS-1:0];
    end
    if (cmd_i.pop || cmd_i.rep_read) begin
      rd_data_q <= mem[rd_addr];
    end
    if (cmd_i.rep_setup) begin
      rp_q <= first_slot;
    end else if (cmd_i.rep_read) begin
      rp_q <= inc(rp_q);
    end
    res_q <= res_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      count_q     <= '0;
      rd_valid_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      rd_valid_q  <= cmd_i.pop || cmd_i.rep_read;
      rd_last_q   <= cmd_i.rd_last;
      res_valid_q <= direct || rd_valid_q;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

`default_nettype wire

### rtl/core/overwriting_history_fifo_core.sv
// Channel    Handshake                 Payload          Direction
// request    start high, busy low      in_i (ohf_in_t)  in
// result     res_valid_o, one cycle    res_o (ohf_out_t) out
//
// Push and refusals: result in the cycle after acceptance, busy stays low,
// so one item per cycle. Pop and replay of N (N results, back to back):
// busy stays high until the last result appears; each result goes through
// the registered read data of the single read port of the entry store and
// then the result register; replay first loads its read pointer.
// Reset empties the FIFO at once; store contents stay undefined until written.
// The receiver cannot stall: every result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "overwriting_history_fifo_core_defines.svh"

module overwriting_history_fifo_core #(
  parameter int DEPTH      = 16,
  parameter int ENTRY_BITS = 64
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  ohf_pkg::ohf_in_t  in_i,
  output ohf_pkg::ohf_out_t res_o,
  output logic              res_valid_o
);
  import ohf_pkg::*;

  ohf_cmd_t    cmd;
  ohf_status_t status;

  ohf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ohf_dpath #(
    .DEPTH      (DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  // direct results never collide with a pending read
  `OHF_ASSERT_HOLDS(a_no_collision, clk_i, rst_ni, !((cmd.push || cmd.refuse) && status.rd_pend), "direct result collides with read data")

  // an accepted item either gives a result next cycle or keeps the block busy
  `OHF_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start && !busy, res_valid_o || busy, "accepted item neither answered nor in progress")

  // refusals carry zero data and close their run
  `OHF_ASSERT_HOLDS(a_refuse_form, clk_i, rst_ni, !(res_valid_o && res_o.refused) || (res_o.out_data == '0 && res_o.last_of_run), "malformed refusal")

  // replay results come back to back until the last
  `OHF_ASSERT_NEXT(a_run_contiguous, clk_i, rst_ni, res_valid_o && !res_o.last_of_run, res_valid_o, "gap inside a replay run")

endmodule

`default_nettype wire
